FILE: rtl/core/horspool_substring_search_assert.svh
// assertion macros for the substring search block
`ifndef HORSPOOL_SUBSTRING_SEARCH_ASSERT_SVH
`define HORSPOOL_SUBSTRING_SEARCH_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define HSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define HSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/hss_pkg.sv
package hss_pkg;

	localparam int LEN_W = 5;
	localparam int CFG_W = 64;

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		CFG_PAT_LO  = 2'd0,
		CFG_PAT_HI  = 2'd1,
		CFG_PAT_LEN = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic hit;
		logic occ;
	} cell_res_t;

	// printable bytes keep their value, all others share class zero
	function automatic byte_t char_class(input byte_t b);
		byte_t c;
		c = ((b >= 8'd32) && (b <= 8'd126)) ? b : 8'd0;
		return c;
	endfunction

endpackage

FILE: rtl/core/hss_cell.sv
module hss_cell (
	input  logic              clk,
	input  logic              shift_en,
	input  hss_pkg::byte_t    din,
	output hss_pkg::byte_t    dout,
	input  hss_pkg::byte_t    aligned_byte,
	input  logic              align_on,
	input  hss_pkg::byte_t    pat_raw,
	input  logic              occ_on,
	input  hss_pkg::byte_t    text_class,
	output hss_pkg::cell_res_t res
);

	hss_pkg::byte_t window_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			window_q <= din;
		end
	end

	assign dout = window_q;

	// compare the incoming window byte, and check pattern class against text class
	assign res.hit = !align_on || (din == aligned_byte);
	assign res.occ = occ_on && (hss_pkg::char_class(pat_raw) == text_class);

endmodule

FILE: rtl/core/horspool_substring_search.sv
// result: a result is registered in the cycle after the request that causes it
// throughput: one text byte per cycle; window compare and shift select are done
// in parallel over the cell row, gated only by a stalled result register
// reset: pattern cleared, length 1, byte index zero, no result pending;
// window bytes are not reset
module horspool_substring_search #(
	parameter int PATTERN_MAX = 16,
	parameter int INDEX_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  text_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        found,
	output logic [31:0] match_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	`include "horspool_substring_search_assert.svh"

	logic [hss_pkg::CFG_W-1:0] pat_lo_q;
	logic [hss_pkg::CFG_W-1:0] pat_hi_q;
	logic [hss_pkg::LEN_W-1:0] plen_q;
	logic [hss_pkg::LEN_W-1:0] len;

	hss_pkg::byte_t pat [16];
	hss_pkg::byte_t apat [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] align_on;
	logic [PATTERN_MAX-1:0] occ_on;
	hss_pkg::byte_t chain [PATTERN_MAX+1];
	hss_pkg::cell_res_t res [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] hits;
	logic [PATTERN_MAX-1:0] occs;
	hss_pkg::byte_t text_class;
	logic [hss_pkg::LEN_W-1:0] shift_amt;

	logic [INDEX_BITS-1:0] byte_index_q, byte_index_d;
	logic [INDEX_BITS-1:0] next_check_q, next_check_d;
	logic                  done_q, done_d;
	logic [INDEX_BITS-1:0] cur_check;
	logic [INDEX_BITS-1:0] idx_inc;
	logic [INDEX_BITS-1:0] len_m1;
	logic                  at_check;
	logic                  hit_now;
	logic                  accept;
	logic                  shift_en;

	logic        load_res;
	logic        found_d;
	logic [31:0] match_end_d;
	logic        found_q;
	logic [31:0] match_end_q;
	logic        result_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			plen_q   <= hss_pkg::LEN_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				hss_pkg::CFG_PAT_LO:  pat_lo_q <= cfg_data;
				hss_pkg::CFG_PAT_HI:  pat_hi_q <= cfg_data;
				hss_pkg::CFG_PAT_LEN: plen_q   <= cfg_data[hss_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// effective length, clamped to 1..PATTERN_MAX
	always_comb begin
		if (plen_q == '0) begin
			len = hss_pkg::LEN_W'(1);
		end else if (plen_q > hss_pkg::LEN_W'(PATTERN_MAX)) begin
			len = hss_pkg::LEN_W'(PATTERN_MAX);
		end else begin
			len = plen_q;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			pat[i]     = pat_lo_q[8*i +: 8];
			pat[i + 8] = pat_hi_q[8*i +: 8];
		end
	end

	// pattern byte aligned to each window position, newest byte at cell 0
	always_comb begin
		logic [hss_pkg::LEN_W-1:0] pidx;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			pidx        = len - hss_pkg::LEN_W'(k) - hss_pkg::LEN_W'(1);
			align_on[k] = hss_pkg::LEN_W'(k) < len;
			occ_on[k]   = (hss_pkg::LEN_W'(k) + hss_pkg::LEN_W'(1)) < len;
			apat[k]     = pat[pidx[3:0]];
		end
	end

	assign text_class = hss_pkg::char_class(text_byte);
	assign chain[0]   = text_byte;

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		hss_cell u_cell (
			.clk          (clk),
			.shift_en     (shift_en),
			.din          (chain[k]),
			.dout         (chain[k+1]),
			.aligned_byte (apat[k]),
			.align_on     (align_on[k]),
			.pat_raw      (pat[k]),
			.occ_on       (occ_on[k]),
			.text_class   (text_class),
			.res          (res[k])
		);
		assign hits[k] = res[k].hit;
		assign occs[k] = res[k].occ;
	end

	// bad-character shift: last earlier occurrence wins
	always_comb begin
		shift_amt = len;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (occs[i]) begin
				shift_amt = len - hss_pkg::LEN_W'(i) - hss_pkg::LEN_W'(1);
			end
		end
	end

	assign text_ready = !result_valid_q || result_ready;
	assign accept     = text_valid && text_ready;
	assign shift_en   = accept && !done_q;

	assign len_m1    = INDEX_BITS'(len - hss_pkg::LEN_W'(1));
	assign cur_check = (byte_index_q == '0) ? len_m1 : next_check_q;
	assign idx_inc   = byte_index_q + INDEX_BITS'(1);
	assign at_check  = byte_index_q == cur_check;
	assign hit_now   = at_check && (&hits);

	always_comb begin
		byte_index_d = byte_index_q;
		next_check_d = next_check_q;
		done_d       = done_q;
		load_res     = 1'b0;
		found_d      = 1'b0;
		match_end_d  = '0;
		if (accept) begin
			if (done_q) begin
				if (last_byte) begin
					byte_index_d = '0;
					next_check_d = len_m1;
					done_d       = 1'b0;
				end else begin
					byte_index_d = idx_inc;
				end
			end else if (hit_now) begin
				load_res    = 1'b1;
				found_d     = 1'b1;
				match_end_d = 32'(byte_index_q);
				if (last_byte) begin
					byte_index_d = '0;
					next_check_d = len_m1;
				end else begin
					done_d       = 1'b1;
					byte_index_d = idx_inc;
					next_check_d = cur_check;
				end
			end else begin
				if (last_byte) begin
					load_res     = 1'b1;
					byte_index_d = '0;
					next_check_d = len_m1;
				end else begin
					byte_index_d = idx_inc;
					next_check_d = at_check ? (byte_index_q + INDEX_BITS'(shift_amt))
						: cur_check;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q   <= '0;
			next_check_q   <= '0;
			done_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			byte_index_q <= byte_index_d;
			next_check_q <= next_check_d;
			done_q       <= done_d;
			if (load_res) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			found_q     <= found_d;
			match_end_q <= match_end_d;
		end
	end

	assign result_valid = result_valid_q;
	assign found        = found_q;
	assign match_end    = match_end_q;

	`HSS_ASSERT_NOW(a_nomatch_zero_end, result_valid && !found, match_end == '0,
		"end-of-text result without match carries nonzero end index")
	`HSS_ASSERT_NOW(a_stall_only_when_full, !text_ready, result_valid && !result_ready,
		"text request stalled while result slot is free")
	`HSS_ASSERT_NEXT(a_silent_after_match,
		accept && done_q && !(result_valid && !result_ready), !result_valid,
		"result produced after a match within the same text")
	`HSS_ASSERT_NEXT(a_match_sets_done, accept && !done_q && hit_now && !last_byte, done_q,
		"match inside a text did not end the search")

endmodule
